@@ sv/upm_pkg.sv @@
package upm_pkg;

    // Field widths fixed by the pixel formats.
    localparam int ChanW   = 16;
    localparam int ByteW   = 8;
    localparam int NumW    = 2 * ChanW;
    localparam int NumChan = 3;
    localparam int NumCell = ChanW;

    // Color lane order inside the divider data.
    localparam int LaneBlue  = 0;
    localparam int LaneGreen = 1;
    localparam int LaneRed   = 2;

    localparam logic [ChanW-1:0] Full16 = 16'hFFFF;
    localparam logic [23:0]      Half16 = 24'h007FFF;

    // Data that moves down the divider chain. Each work word holds the partial
    // remainder in its upper half and the shifting numerator/quotient in its
    // lower half.
    typedef struct packed {
        logic [ChanW-1:0]              alpha;
        logic [NumChan-1:0]            ovf;
        logic [NumChan-1:0][NumW-1:0]  work;
    } t_div_data;

    // Rounded scale of a 16-bit value to 8 bits: (v * 255 + 0x7FFF) / 0xFFFF.
    // The quotient by 0xFFFF is the top byte plus one correction step.
    function automatic logic [ByteW-1:0] scale_to8(input logic [ChanW-1:0] v);
        logic [23:0]      x;
        logic [ByteW-1:0] t;
        logic [ChanW:0]   rm;
        x  = ({v, 8'h00} - {8'h00, v}) + Half16;
        t  = x[23:16];
        rm = {1'b0, x[15:0]} + {9'h000, t};
        return (rm >= {1'b0, Full16}) ? t + 8'd1 : t;
    endfunction

    // Rounded numerator of the unpremultiply quotient: c * 0xFFFF + alpha / 2.
    function automatic logic [NumW-1:0] numer(input logic [ChanW-1:0] c,
                                              input logic [ChanW-1:0] a);
        return ({c, 16'h0000} - {16'h0000, c}) + {17'h00000, a[ChanW-1:1]};
    endfunction

endpackage

@@ sv/upm_prep.sv @@
module upm_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [15:0]         i_blue,
    input  logic [15:0]         i_green,
    input  logic [15:0]         i_red,
    input  logic [15:0]         i_alpha,
    output logic                o_valid,
    input  logic                i_ready,
    output upm_pkg::t_div_data  o_data
);

    logic               r_valid;
    upm_pkg::t_div_data r_data;
    upm_pkg::t_div_data n_data;
    logic [upm_pkg::NumChan-1:0][upm_pkg::ChanW-1:0] chan;

    assign chan[upm_pkg::LaneBlue]  = i_blue;
    assign chan[upm_pkg::LaneGreen] = i_green;
    assign chan[upm_pkg::LaneRed]   = i_red;

    // Build the numerators. A quotient above 0xFFFF shows as a top half that
    // already reaches alpha, so those lanes are flagged for clamping.
    always_comb begin
        n_data.alpha = i_alpha;
        for (int k = 0; k < upm_pkg::NumChan; k++) begin
            n_data.work[k] = upm_pkg::numer(chan[k], i_alpha);
            n_data.ovf[k]  = (n_data.work[k][upm_pkg::NumW-1:upm_pkg::ChanW] >= i_alpha);
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ sv/upm_cell.sv @@
module upm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  upm_pkg::t_div_data  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output upm_pkg::t_div_data  o_data
);

    logic               r_valid;
    upm_pkg::t_div_data r_data;
    upm_pkg::t_div_data n_data;
    logic [upm_pkg::ChanW:0] trial [upm_pkg::NumChan];
    logic [upm_pkg::NumChan-1:0] take;

    // One restoring division step per lane: bring down the next numerator bit,
    // subtract alpha when it fits, and shift the quotient bit in at the bottom.
    always_comb begin
        n_data = i_data;
        for (int k = 0; k < upm_pkg::NumChan; k++) begin
            trial[k] = i_data.work[k][upm_pkg::NumW-1:upm_pkg::ChanW-1];
            take[k]  = (trial[k] >= {1'b0, i_data.alpha});
            if (take[k]) begin
                trial[k] = trial[k] - {1'b0, i_data.alpha};
            end
            n_data.work[k] = {trial[k][upm_pkg::ChanW-1:0],
                              i_data.work[k][upm_pkg::ChanW-2:0], take[k]};
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

@@ sv/upm_pack.sv @@
module upm_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  upm_pkg::t_div_data  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_argb_pixel
);

    logic        r_valid;
    logic [31:0] r_pixel;
    logic [31:0] n_pixel;
    logic [upm_pkg::ChanW-1:0] straight [upm_pkg::NumChan];
    logic [upm_pkg::ByteW-1:0] col8 [upm_pkg::NumChan];

    // Clamp each quotient, scale all four channels to bytes and pack them.
    // Zero alpha forces the color bytes to zero.
    always_comb begin
        for (int k = 0; k < upm_pkg::NumChan; k++) begin
            straight[k] = i_data.ovf[k] ? upm_pkg::Full16
                                        : i_data.work[k][upm_pkg::ChanW-1:0];
            col8[k] = (i_data.alpha == '0) ? '0 : upm_pkg::scale_to8(straight[k]);
        end
        n_pixel = {upm_pkg::scale_to8(i_data.alpha), col8[upm_pkg::LaneRed],
                   col8[upm_pkg::LaneGreen], col8[upm_pkg::LaneBlue]};
    end

    assign o_ready      = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_argb_pixel = r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pixel <= n_pixel;
        end
    end

endmodule

@@ sv/unpremultiply_rgba16_to_argb8.sv @@
// Converts premultiplied 16-bit BGRA pixels into packed ARGB8 pixels with
// straight alpha (alpha 31:24, red 23:16, green 15:8, blue 7:0). It takes
// one pixel per cycle unless i_ready stalls the output: one stage forms
// the rounded numerators, a row of 16 division cells produces one quotient bit
// each for all three colors at once, and a final stage clamps, rounds to 8 bits
// and registers the result. Every stage has its own valid bit, so empty stages
// keep filling while a finished result waits on o_ready's partner i_ready.
// A pixel with zero alpha comes out as all zeros.
module unpremultiply_rgba16_to_argb8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_blue,
    input  logic [15:0] i_green,
    input  logic [15:0] i_red,
    input  logic [15:0] i_alpha,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_argb_pixel
);

    upm_pkg::t_div_data          chain_data  [upm_pkg::NumCell+1];
    logic [upm_pkg::NumCell:0]   chain_valid;
    logic [upm_pkg::NumCell:0]   chain_ready;

    // Numerator stage.
    upm_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_blue  (i_blue),
        .i_green (i_green),
        .i_red   (i_red),
        .i_alpha (i_alpha),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_data  (chain_data[0])
    );

    // Division chain, most significant quotient bit first.
    for (genvar g = 0; g < upm_pkg::NumCell; g++) begin : g_cell
        upm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    // Clamp, scale and pack.
    upm_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (chain_valid[upm_pkg::NumCell]),
        .o_ready      (chain_ready[upm_pkg::NumCell]),
        .i_data       (chain_data[upm_pkg::NumCell]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_argb_pixel (o_argb_pixel)
    );

    // Input back-pressure only happens when every stage is full and the output
    // is stalled.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready && (&chain_valid)))
        else $error("input stalled while the pipeline has room");

    // Alpha travels unchanged from the numerator stage into the first cell.
    a_alpha_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain_valid[0] && chain_ready[1]) |=>
        (chain_data[1].alpha == $past(chain_data[0].alpha)))
        else $error("alpha corrupted in the division chain");

    // At the end of the chain, a blue or red lane that did not overflow leaves a
    // remainder below alpha.
    a_rem_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain_valid[upm_pkg::NumCell] && !chain_data[upm_pkg::NumCell].ovf[upm_pkg::LaneBlue]
         && (chain_data[upm_pkg::NumCell].alpha != '0)) |->
        (chain_data[upm_pkg::NumCell].work[upm_pkg::LaneBlue][31:16]
         < chain_data[upm_pkg::NumCell].alpha))
        else $error("blue remainder not below alpha");

    a_rem_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain_valid[upm_pkg::NumCell] && !chain_data[upm_pkg::NumCell].ovf[upm_pkg::LaneRed]
         && (chain_data[upm_pkg::NumCell].alpha != '0)) |->
        (chain_data[upm_pkg::NumCell].work[upm_pkg::LaneRed][31:16]
         < chain_data[upm_pkg::NumCell].alpha))
        else $error("red remainder not below alpha");

endmodule

@@ verif/tb_top.sv @@
module tb_top;

    localparam int RandPerPhase = 585;
    localparam int HoldCycles   = 120;
    localparam int DrainCycles  = 40;
    localparam int MaxPrinted   = 100;

    // Holds the straight-alpha pixels still owed by the block and checks each
    // output transaction against the oldest one.
    class pixel_scoreboard;
        logic [31:0] pending_pixels[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Rounded scale of a 16-bit channel down to one byte.
        function logic [upm_pkg::ByteW-1:0] round_to_byte(
            input logic [upm_pkg::ChanW-1:0] v);
            logic [63:0] p;
            p = (64'(v) * 64'd255 + 64'h7FFF) / 64'hFFFF;
            return p[upm_pkg::ByteW-1:0];
        endfunction

        // Divides a premultiplied color by a nonzero alpha with rounding and
        // clamps the quotient to full scale.
        function logic [upm_pkg::ChanW-1:0] unmix(input logic [upm_pkg::ChanW-1:0] c,
                                                  input logic [upm_pkg::ChanW-1:0] a);
            logic [63:0] q;
            q = (64'(c) * 64'hFFFF + 64'(a >> 1)) / 64'(a);
            if (q > 64'hFFFF) begin
                q = 64'hFFFF;
            end
            return q[upm_pkg::ChanW-1:0];
        endfunction

        function logic [31:0] straight_argb(input logic [upm_pkg::ChanW-1:0] b,
                                            input logic [upm_pkg::ChanW-1:0] g,
                                            input logic [upm_pkg::ChanW-1:0] r,
                                            input logic [upm_pkg::ChanW-1:0] a);
            logic [31:0] px;
            px = {round_to_byte(a), 24'h000000};
            // Fully transparent pixels keep all color bytes at zero.
            if (a != '0) begin
                px[23:0] = {round_to_byte(unmix(r, a)), round_to_byte(unmix(g, a)),
                            round_to_byte(unmix(b, a))};
            end
            return px;
        endfunction

        function void note_pixel(input logic [upm_pkg::ChanW-1:0] b,
                                 input logic [upm_pkg::ChanW-1:0] g,
                                 input logic [upm_pkg::ChanW-1:0] r,
                                 input logic [upm_pkg::ChanW-1:0] a);
            pending_pixels.push_back(straight_argb(b, g, r, a));
        endfunction

        task report_mismatch(input string what);
            if (errors < MaxPrinted) begin
                $display("ERROR at %0t: %s", $realtime, what);
            end
            errors++;
        endtask

        task check_pixel(input logic [31:0] got);
            logic [31:0] want;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel %08h with no transaction pending", got));
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("argb_pixel %08h, expected %08h", got, want));
                end
            end
        endtask
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [15:0] i_blue       = '0;
    logic [15:0] i_green      = '0;
    logic [15:0] i_red        = '0;
    logic [15:0] i_alpha      = '0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_argb_pixel;

    int   send_idle_pct = 25;
    int   recv_idle_pct = 59;
    logic hold_req      = 1'b0;
    logic rx_hold       = 1'b0;

    pixel_scoreboard sb = new();

    unpremultiply_rgba16_to_argb8 u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .i_alpha      (i_alpha),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_argb_pixel (o_argb_pixel)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Offers one pixel, starting at a falling edge, and returns at the falling
    // edge after the transaction is accepted. Valid stays high between
    // back-to-back pixels.
    task automatic send_pixel(input logic [15:0] b, input logic [15:0] g,
                              input logic [15:0] r, input logic [15:0] a);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_blue  = b;
        i_green = g;
        i_red   = r;
        i_alpha = a;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        sb.note_pixel(b, g, r, a);
        @(negedge i_clk);
    endtask

    // Edge cases: transparent pixels, the smallest and largest alpha, colors
    // above alpha, exact rounding halves and alphas that round to a zero byte.
    task automatic send_directed();
        send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_pixel(16'h1234, 16'h8001, 16'h00FF, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0001);
        send_pixel(16'h0001, 16'h0000, 16'h0001, 16'h0001);
        send_pixel(16'hFFFF, 16'h8000, 16'h0002, 16'h0001);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_pixel(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF);
        send_pixel(16'h0001, 16'h0000, 16'h0002, 16'h0002);
        send_pixel(16'h0001, 16'h0002, 16'h0003, 16'h0003);
        send_pixel(16'h4000, 16'h8000, 16'h8001, 16'h8000);
        send_pixel(16'h0040, 16'h0080, 16'h007F, 16'h0080);
        send_pixel(16'h0040, 16'h0081, 16'h0001, 16'h0081);
        send_pixel(16'h3FFF, 16'h4000, 16'h7FFE, 16'h7FFF);
        send_pixel(16'h5555, 16'hAAAA, 16'h0000, 16'hAAAA);
        send_pixel(16'hAAAA, 16'h5555, 16'h2AAA, 16'h5555);
        send_pixel(16'hFFFF, 16'hFFFE, 16'h7FFF, 16'hFFFE);
        send_pixel(16'h0080, 16'h0081, 16'h0100, 16'h0101);
        send_pixel(16'h7FBF, 16'hFF7F, 16'h0001, 16'hFF7F);
    endtask

    // Mostly valid premultiplied pixels (every color at most alpha), with some
    // transparent pixels and some fully random ones.
    task automatic send_random(input int count);
        int          kind;
        logic [15:0] a;
        repeat (count) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                send_pixel(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000);
            end else if (kind < 20) begin
                send_pixel(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                case ($urandom_range(9))
                    0:       a = 16'($urandom_range(255, 1));
                    1:       a = 16'hFFFF;
                    default: a = 16'($urandom_range(16'hFFFF, 1));
                endcase
                send_pixel(16'($urandom_range(a, 0)), 16'($urandom_range(a, 0)),
                           16'($urandom_range(a, 0)), a);
            end
        end
    endtask

    // Receiver side: random back-pressure, or a full hold-off when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            i_ready = 1'b0;
        end else begin
            i_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every output transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_pixel(o_argb_pixel);
        end
    end

    // Long receiver hold-off so the pipeline fills and stalls its input.
    initial begin
        wait (hold_req);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    // Main sequence: reset, directed pixels, then three idling phases.
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        send_directed();
        send_random(RandPerPhase);
        send_idle_pct <= 59;
        recv_idle_pct <= 25;
        send_random(RandPerPhase);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_req = 1'b1;
        send_random(RandPerPhase);
        i_valid = 1'b0;
        while (sb.pending_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DrainCycles) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
